### rtl/fwmq_pkg.sv
// fwmq_pkg: shared types and codes for the FIFO with membership query.
// Used by every module of the block; depends on nothing.

package fwmq_pkg;

	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_DEQ = 2'd1;
	localparam logic [1:0] MODE_QRY = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data_out;
		logic               found;
		logic [4:0]         count;
	} rsp_t;

	typedef struct packed {
		logic enq;
		logic deq;
		logic qry;
	} op_t;

endpackage

### rtl/fwmq_ptr.sv
// fwmq_ptr: head, tail and fill count of the ring, plus operation decode and status.
// Depends on fwmq_pkg.

module fwmq_ptr
	import fwmq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  logic [1:0]    mode,
	output op_t           op,
	output logic [IW-1:0] head,
	output logic [IW-1:0] tail,
	output logic [CW-1:0] cnt,
	output logic [CW-1:0] cnt_nxt,
	output logic [1:0]    status
);

	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] cnt_q;
	logic          full;
	logic          empty;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);

	always_comb begin
		op     = '0;
		status = STAT_OK;
		case (mode)
			MODE_ENQ: begin
				op.enq = valid && !full;
				if (full)
					status = STAT_FULL;
			end
			MODE_DEQ: begin
				op.deq = valid && !empty;
				if (empty)
					status = STAT_EMPTY;
			end
			MODE_QRY: begin
				op.qry = valid;
			end
			default: begin
				op = '0;
			end
		endcase
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (op.enq)
			cnt_nxt = cnt_q + CW'(1);
		else if (op.deq)
			cnt_nxt = cnt_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			cnt_q <= cnt_nxt;
			if (op.enq)
				tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + IW'(1);
			if (op.deq)
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
		end
	end

	assign head = head_q;
	assign tail = tail_q;
	assign cnt  = cnt_q;

endmodule

### rtl/fwmq_store.sv
// fwmq_store: entry cells with a comparator each; head read and key match.
// Depends on fwmq_pkg.

module fwmq_store
	import fwmq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  op_t                op,
	input  logic [IW-1:0]      wr_idx,
	input  logic [IW-1:0]      head,
	input  logic [CW-1:0]      cnt,
	input  logic signed [31:0] value,
	output logic signed [31:0] rd_data,
	output logic               found
);

	logic signed [31:0] cell_q [DEPTH];
	logic [DEPTH-1:0]   match;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [IW:0] off;

		always_ff @(posedge clk) begin
			if (op.enq && (wr_idx == IW'(i)))
				cell_q[i] <= value;
		end

		// offset of this slot from the head, modulo DEPTH
		always_comb begin
			if (IW'(i) >= head)
				off = (IW+1)'(i) - {1'b0, head};
			else
				off = (IW+1)'(i) + (IW+1)'(DEPTH) - {1'b0, head};
		end

		assign match[i] = ((IW+1)'(off) < (IW+1)'(cnt)) && (cell_q[i] == value);
	end

	assign rd_data = cell_q[head];
	assign found   = op.qry && (|match);

endmodule

### rtl/fifo_with_membership_query_top.sv
// fifo_with_membership_query_top: top level of the FIFO with membership query.
// Depends on fwmq_pkg, fwmq_ptr and fwmq_store.

// A word is taken whenever start is high; busy never rises, so one operation
// can be issued every cycle. Its result shows on rsp, marked by a strobe that
// is high for one cycle, once the word has passed one input register, then the
// pointer update, head read and the compare of the key against every held
// entry in parallel, then the result register. The receiver cannot stall.
// Every result carries the count after the operation, truncated to five bits.

module fifo_with_membership_query_top
	import fwmq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic strobe,
	output rsp_t rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic               valid_s1;
	req_t               req_s1;
	logic               strobe_q;
	rsp_t               rsp_q;
	op_t                op;
	logic [IW-1:0]      head;
	logic [IW-1:0]      tail;
	logic [CW-1:0]      cnt;
	logic [CW-1:0]      cnt_nxt;
	logic [1:0]         status;
	logic signed [31:0] rd_data;
	logic               found;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			strobe_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			req_s1 <= req;
		if (valid_s1) begin
			rsp_q.status   <= status;
			rsp_q.data_out <= op.deq ? rd_data : '0;
			rsp_q.found    <= found;
			rsp_q.count    <= 5'(cnt_nxt);
		end
	end

	fwmq_ptr #(.DEPTH(DEPTH), .IW(IW), .CW(CW)) u_ptr (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (valid_s1),
		.mode    (req_s1.mode),
		.op      (op),
		.head    (head),
		.tail    (tail),
		.cnt     (cnt),
		.cnt_nxt (cnt_nxt),
		.status  (status)
	);

	fwmq_store #(.DEPTH(DEPTH), .IW(IW), .CW(CW)) u_store (
		.clk     (clk),
		.op      (op),
		.wr_idx  (tail),
		.head    (head),
		.cnt     (cnt),
		.value   (req_s1.value),
		.rd_data (rd_data),
		.found   (found)
	);

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule

### rtl/fwmq_chk.sv
// fwmq_chk: port-level checks of the FIFO with membership query, bound to the top.
// Depends on fwmq_pkg and fifo_with_membership_query_top.

module fwmq_chk
	import fwmq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic strobe,
	input rsp_t rsp
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 strobe)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, 2))
		else $error("result without accepted word");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rsp.status == STAT_EMPTY) |-> (rsp.count == '0 && rsp.data_out == '0))
		else $error("refused dequeue with nonzero count or data");

	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rsp.status == STAT_FULL) |-> (rsp.count == 5'(DEPTH) && !rsp.found))
		else $error("refused enqueue with wrong count");

	a_found_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rsp.found) |-> (rsp.status == STAT_OK && rsp.data_out == '0))
		else $error("query hit with wrong status or data");

endmodule

bind fifo_with_membership_query_top fwmq_chk #(.DEPTH(DEPTH)) u_chk (.*);
